// File: hdl/hbfb_pkg.sv
// Package for the Bloom filter bank: beat types, register map, FSM states.
// No dependencies.
`default_nettype none
package hbfb_pkg;
   typedef struct packed {
      logic        action;
      logic [63:0] seed;
      logic [31:0] base_count;
      logic [19:0] group_bit_offset;
      logic        or_with_next;
   } req_type;

   typedef struct packed {
      logic [63:0] hit_bits;
      logic [1:0]  word_number;
      logic        last;
      logic        out_of_range;
   } rsp_type;

   localparam logic [2:0] REG_XOR_KEY     = 3'd0;
   localparam logic [2:0] REG_HASH_BITS   = 3'd1;
   localparam logic [2:0] REG_FILTERS     = 3'd2;
   localparam logic [2:0] REG_SEEDS       = 3'd3;
   localparam logic [2:0] REG_LAYOUT      = 3'd4;

   localparam logic ACT_INSERT = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_DIV, ST_MUL, ST_INS_RD, ST_INS_WAIT, ST_INS_WR,
      ST_Q_RD, ST_Q_NEXT, ST_Q_OUT
   } state_type;
endpackage
`default_nettype wire

// File: hdl/hierarchical_bloom_filter_bank.sv
// Bloom filter bank top level: CSR port, insert/query sequencer, bit memory.
// Depends on hbfb_pkg.
//
// After reset the block clears its memory, one word a cycle, with busy high.
// An insert takes 32 divide steps, then forms the bit index, then does the
// read-modify-write of one word in ST_INS_RD, ST_INS_WAIT and ST_INS_WR
// (skipping ST_INS_WAIT when the index lies beyond memory); its single result
// beat comes in the last of these and busy drops the cycle after. A query
// forms the index in ST_MUL, then reads one bit per cycle through the single
// read port: one read per filter plus one per filter but the last when
// or_with_next is set. ST_Q_NEXT then collects the last bit, and one result
// beat per 64 filters follows, one per cycle.
// The receiver cannot stall; beats go out on rsp_valid for one cycle each.
`default_nettype none
module hierarchical_bloom_filter_bank #(
   parameter int MEM_WORDS   = 32768,
   parameter int MAX_FILTERS = 256
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   output logic                   busy,
   input  wire hbfb_pkg::req_type req_data,
   output logic                   rsp_valid,
   output hbfb_pkg::rsp_type      rsp_data,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire  [5:0]             paddr,
   input  wire  [63:0]            pwdata,
   output logic [63:0]            prdata,
   output logic                   pready
);
   localparam int AW = $clog2(MEM_WORDS);
   localparam logic [49:0] MEM_BITS = 50'(MEM_WORDS) * 50'd32;

   logic [63:0] xor_key_ff;
   logic [4:0]  hash_bits_ff;
   logic [8:0]  filters_ff;
   logic [15:0] seeds_ff;
   logic        layout_ff;

   assign pready = 1'b1;
   wire [2:0] reg_idx = paddr[5:3];
   wire       addr_hi = (paddr[2:0] != 3'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         xor_key_ff     <= '0;
         hash_bits_ff   <= 5'd10;
         filters_ff     <= 9'd256;
         seeds_ff       <= 16'd1;
         layout_ff      <= 1'b1;
      end else if (psel && penable && pwrite && !addr_hi) begin
         case (reg_idx)
            hbfb_pkg::REG_XOR_KEY:     xor_key_ff     <= pwdata;
            hbfb_pkg::REG_HASH_BITS:   hash_bits_ff   <= pwdata[4:0];
            hbfb_pkg::REG_FILTERS:     filters_ff     <= pwdata[8:0];
            hbfb_pkg::REG_SEEDS:       seeds_ff       <= pwdata[15:0];
            hbfb_pkg::REG_LAYOUT:      layout_ff      <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      if (!addr_hi) begin
         case (reg_idx)
            hbfb_pkg::REG_XOR_KEY:     prdata = xor_key_ff;
            hbfb_pkg::REG_HASH_BITS:   prdata = {59'd0, hash_bits_ff};
            hbfb_pkg::REG_FILTERS:     prdata = {55'd0, filters_ff};
            hbfb_pkg::REG_SEEDS:       prdata = {48'd0, seeds_ff};
            hbfb_pkg::REG_LAYOUT:      prdata = {63'd0, layout_ff};
            default: prdata = '0;
         endcase
      end
   end

   // effective configuration
   wire [4:0] hb = (hash_bits_ff > 5'd16) ? 5'd16 : hash_bits_ff;
   wire [8:0] nf_raw = (filters_ff == 9'd0) ? 9'd1 : filters_ff;
   wire [8:0] nf = (nf_raw > 9'(MAX_FILTERS)) ? 9'(MAX_FILTERS) : nf_raw;
   wire [15:0] ns = (seeds_ff == 16'd0) ? 16'd1 : seeds_ff;
   wire [16:0] size = 17'd1 << hb;

   // memory
   logic [31:0] mem [MEM_WORDS];
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [31:0]   wr_data, rd_data_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   hbfb_pkg::state_type state_ff, state_in;
   hbfb_pkg::req_type   req_ff;
   logic [AW-1:0] clr_ff, clr_in;
   logic [16:0]   hash_ff;
   // divider: base / (S*F)
   logic [31:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [49:0] idx_ff, idx_in;
   logic [8:0]  fi_ff, fi_in;
   logic        phase_ff, phase_in;
   logic        oor_ff, oor_in;
   logic        pend_ff, pend_in;
   logic [8:0]  pend_i_ff, pend_i_in;
   logic [255:0] hits_ff, hits_in;
   logic [1:0]  wn_ff, wn_in;
   logic [49:0] sub_ff, sub_in;

   wire [24:0] range = 25'(ns) * 25'(nf);
   wire [25:0] rtry = {rem_ff, quo_ff[31]};
   wire [49:0] step = layout_ff ? 50'd1 : 50'(size);
   wire [49:0] qidx = phase_ff ? idx_ff + step : idx_ff;
   wire        qoor = qidx >= MEM_BITS;
   wire [1:0]  last_wn = 2'((nf - 9'd1) >> 6);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hbfb_pkg::ST_CLEAR;
         clr_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         pend_ff  <= pend_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      idx_ff <= idx_in; fi_ff <= fi_in; phase_ff <= phase_in;
      oor_ff <= oor_in; pend_i_ff <= pend_i_in;
      hits_ff <= hits_in; wn_ff <= wn_in; sub_ff <= sub_in;
      if (start && !busy) begin
         req_ff  <= req_data;
         hash_ff <= 17'(req_data.seed ^ xor_key_ff) & (size - 17'd1);
      end
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff;
      quo_in = quo_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      idx_in = idx_ff; fi_in = fi_ff; phase_in = phase_ff;
      oor_in = oor_ff; pend_in = 1'b0; pend_i_in = pend_i_ff;
      hits_in = hits_ff; wn_in = wn_ff; sub_in = sub_ff;
      busy = 1'b1; rsp_valid = 1'b0; rsp_data = '0;
      rd_addr = '0; wr_addr = clr_ff; wr_en = 1'b0; wr_data = '0;
      // collect bit read issued last cycle
      if (pend_ff) begin
         if (rd_data_ff[5'd31 - 5'(sub_ff[4:0])]) hits_in[pend_i_ff[7:0]] = 1'b1;
      end
      case (state_ff)
         hbfb_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(MEM_WORDS - 1)) state_in = hbfb_pkg::ST_IDLE;
         end
         hbfb_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               oor_in = 1'b0; hits_in = '0; wn_in = '0;
               fi_in = '0; phase_in = 1'b0;
               if (req_data.action == hbfb_pkg::ACT_INSERT) begin
                  quo_in = req_data.base_count; rem_in = '0; cnt_in = '0;
                  state_in = hbfb_pkg::ST_DIV;
               end else begin
                  state_in = hbfb_pkg::ST_MUL;
               end
            end
         end
         hbfb_pkg::ST_DIV: begin
            if (rtry >= 26'(range)) begin
               rem_in = 25'(rtry - 26'(range));
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = rtry[24:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               state_in = hbfb_pkg::ST_MUL;
               cnt_in = '0;
            end
         end
         hbfb_pkg::ST_MUL: begin
            // insert: filter = rem / S (<=255, 8 steps); group start = G*F*size
            if (req_ff.action == hbfb_pkg::ACT_INSERT) begin
               if (cnt_ff == 6'd0) begin
                  idx_in = (50'(quo_ff) * 50'(nf)) << hb;
                  fi_in = '0;
                  sub_in = 50'(rem_ff);
                  cnt_in = 6'd1;
               end else if (cnt_ff <= 6'd8) begin
                  if (sub_ff >= (50'(ns) << (6'd8 - cnt_ff))) begin
                     sub_in = sub_ff - (50'(ns) << (6'd8 - cnt_ff));
                     fi_in = fi_ff | (9'd1 << (6'd8 - cnt_ff));
                  end
                  cnt_in = cnt_ff + 6'd1;
               end else begin
                  if (layout_ff) idx_in = idx_ff + 50'(hash_ff) * 50'(nf) + 50'(fi_ff);
                  else idx_in = idx_ff + 50'(hash_ff) + (50'(fi_ff) << hb);
                  state_in = hbfb_pkg::ST_INS_RD;
               end
            end else begin
               if (layout_ff) idx_in = 50'(req_ff.group_bit_offset) + 50'(hash_ff) * 50'(nf);
               else idx_in = 50'(req_ff.group_bit_offset) + 50'(hash_ff);
               state_in = hbfb_pkg::ST_Q_RD;
            end
         end
         hbfb_pkg::ST_INS_RD: begin
            rd_addr = AW'(idx_ff >> 5);
            if (idx_ff >= MEM_BITS) begin
               oor_in = 1'b1;
               state_in = hbfb_pkg::ST_INS_WR;
            end else state_in = hbfb_pkg::ST_INS_WAIT;
         end
         hbfb_pkg::ST_INS_WAIT: begin
            rd_addr = AW'(idx_ff >> 5);
            state_in = hbfb_pkg::ST_INS_WR;
         end
         hbfb_pkg::ST_INS_WR: begin
            if (!oor_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff >> 5);
               wr_data = rd_data_ff | (32'h8000_0000 >> idx_ff[4:0]);
            end
            rsp_valid = 1'b1;
            rsp_data.last = 1'b1;
            rsp_data.out_of_range = oor_ff;
            state_in = hbfb_pkg::ST_IDLE;
         end
         hbfb_pkg::ST_Q_RD: begin
            rd_addr = AW'(qidx >> 5);
            sub_in = qidx;
            pend_i_in = fi_ff;
            if (qoor) oor_in = 1'b1;
            else pend_in = 1'b1;
            if (!phase_ff && req_ff.or_with_next && (fi_ff + 9'd1 < nf)) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               fi_in = fi_ff + 9'd1;
               if (layout_ff) idx_in = idx_ff + 50'd1;
               else idx_in = idx_ff + 50'(size);
               if (fi_ff + 9'd1 >= nf) state_in = hbfb_pkg::ST_Q_NEXT;
            end
         end
         hbfb_pkg::ST_Q_NEXT: state_in = hbfb_pkg::ST_Q_OUT;
         hbfb_pkg::ST_Q_OUT: begin
            rsp_valid = 1'b1;
            rsp_data.hit_bits = hits_ff[64*wn_ff +: 64];
            rsp_data.word_number = wn_ff;
            rsp_data.last = (wn_ff == last_wn);
            rsp_data.out_of_range = oor_ff;
            wn_in = wn_ff + 2'd1;
            if (wn_ff == last_wn) state_in = hbfb_pkg::ST_IDLE;
         end
         default: state_in = hbfb_pkg::ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

// File: dv/hierarchical_bloom_filter_bank_tb.sv
// Testbench for hierarchical_bloom_filter_bank: directed and random inserts and
// queries checked beat by beat against an in-bench bit-memory predictor.
// Depends on hbfb_pkg and the hierarchical_bloom_filter_bank RTL.
`timescale 1ns / 100ps
`default_nettype none
module hierarchical_bloom_filter_bank_tb;

   localparam int MEM_BITS = 32768 * 32;
   localparam int STALL_LIMIT = 100000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   hbfb_pkg::req_type req_data = '0;
   logic rsp_valid;
   hbfb_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [5:0] paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic pready;

   bit filter_mem [0:MEM_BITS-1];
   longint unsigned xor_key;
   int unsigned hash_bits, filters, seeds, layout;
   hbfb_pkg::rsp_type pending_beats[$];
   longint unsigned seed_pool[8];
   int errors = 0;
   int idle_cycles = 0;
   bit gaps_on = 1'b1;

   hierarchical_bloom_filter_bank i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   function automatic bit read_mem(longint unsigned idx, ref bit oor);
      if (idx >= MEM_BITS) begin
         oor = 1'b1;
         return 1'b0;
      end
      return filter_mem[idx];
   endfunction

   task automatic predict_beats(hbfb_pkg::req_type r);
      int unsigned hb, nf, ns, cnt;
      longint unsigned size, hsh, rng, grp, filt, idx, stp, start_bit;
      logic [63:0] words[4];
      bit oor, hit;
      hbfb_pkg::rsp_type b;
      hb = (hash_bits > 16) ? 16 : hash_bits;
      nf = (filters == 0) ? 1 : (filters > 256 ? 256 : filters);
      ns = (seeds == 0) ? 1 : seeds;
      size = 64'd1 << hb;
      hsh = (r.seed ^ xor_key) & (size - 1);
      oor = 1'b0;
      if (r.action == hbfb_pkg::ACT_INSERT) begin
         rng = ns * nf;
         grp = r.base_count / rng;
         filt = (r.base_count % rng) / ns;
         idx = grp * nf * size + (layout ? hsh * nf + filt : hsh + filt * size);
         if (idx >= MEM_BITS) oor = 1'b1;
         else filter_mem[idx] = 1'b1;
         b = '0;
         b.last = 1'b1;
         b.out_of_range = oor;
         pending_beats.push_back(b);
      end else begin
         start_bit = r.group_bit_offset;
         stp = layout ? 1 : size;
         foreach (words[k]) words[k] = '0;
         for (int unsigned i = 0; i < nf; i++) begin
            idx = layout ? start_bit + hsh * nf + i : start_bit + hsh + i * size;
            hit = read_mem(idx, oor);
            if (r.or_with_next && i + 1 < nf) hit = read_mem(idx + stp, oor) | hit;
            if (hit) words[i >> 6][i & 63] = 1'b1;
         end
         cnt = (nf + 63) / 64;
         for (int k = 0; k < cnt; k++) begin
            b.hit_bits = words[k];
            b.word_number = k[1:0];
            b.last = (k == cnt - 1);
            b.out_of_range = oor;
            pending_beats.push_back(b);
         end
      end
   endtask

   always @(posedge clock) begin
      hbfb_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected result beat %h", rsp_data);
            errors++;
         end else begin
            e = pending_beats.pop_front();
            if (rsp_data.hit_bits !== e.hit_bits) begin
               $error("hit_bits exp %h got %h", e.hit_bits, rsp_data.hit_bits);
               errors++;
            end
            if (rsp_data.word_number !== e.word_number) begin
               $error("word_number exp %0d got %0d", e.word_number, rsp_data.word_number);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last);
               errors++;
            end
            if (rsp_data.out_of_range !== e.out_of_range) begin
               $error("out_of_range exp %0d got %0d", e.out_of_range, rsp_data.out_of_range);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_beat(hbfb_pkg::req_type r);
      if (gaps_on && $urandom_range(99) < 28) repeat ($urandom_range(1, 6)) @(posedge clock);
      @(posedge clock);
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_beats(r);
      start <= 1'b0;
   endtask

   task automatic drain();
      wait (pending_beats.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] reg_index, logic [63:0] value);
      drain();
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {reg_index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (reg_index)
         hbfb_pkg::REG_XOR_KEY:     xor_key = value;
         hbfb_pkg::REG_HASH_BITS:   hash_bits = value[4:0];
         hbfb_pkg::REG_FILTERS:     filters = value[8:0];
         hbfb_pkg::REG_SEEDS:       seeds = value[15:0];
         default:                   layout = value[0];
      endcase
   endtask

   task automatic configure(logic [63:0] hf, int hb, int nf, int ns, int lay);
      write_reg(hbfb_pkg::REG_XOR_KEY, hf);
      write_reg(hbfb_pkg::REG_HASH_BITS, 64'(hb));
      write_reg(hbfb_pkg::REG_FILTERS, 64'(nf));
      write_reg(hbfb_pkg::REG_SEEDS, 64'(ns));
      write_reg(hbfb_pkg::REG_LAYOUT, 64'(lay));
   endtask

   function automatic hbfb_pkg::req_type make_req(int unsigned act, longint unsigned sd,
                                                  int unsigned base, int unsigned offs,
                                                  int unsigned orn);
      hbfb_pkg::req_type r;
      r.action = act[0];
      r.seed = sd;
      r.base_count = base;
      r.group_bit_offset = offs[19:0];
      r.or_with_next = orn[0];
      return r;
   endfunction

   function automatic longint unsigned rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_reset_defaults();
      send_beat(make_req(0, 64'd5, 32'd0, 0, 0));
      send_beat(make_req(0, 64'd5, 32'd1, 0, 0));
      send_beat(make_req(1, 64'd5, 32'd0, 20'd0, 0));
      send_beat(make_req(1, 64'd5, 32'd0, 20'd0, 1));
      send_beat(make_req(0, '1, '1, '1, 1));
      send_beat(make_req(1, '1, '1, '1, 1));
   endtask

   task automatic test_extremes();
      configure('1, 31, 511, 0, 0);
      send_beat(make_req(0, 64'h0, 32'd3, 0, 0));
      send_beat(make_req(0, 64'h1234, 32'd255, 0, 0));
      send_beat(make_req(1, 64'h0, 0, 20'd0, 1));
      send_beat(make_req(1, 64'h1234, 0, 20'hFFFFF, 0));
      configure(64'h0, 0, 0, 65535, 1);
      send_beat(make_req(0, rand64(), 32'd70000, 0, 0));
      send_beat(make_req(1, rand64(), 0, 20'd1, 1));
      send_beat(make_req(0, rand64(), 32'hFFFFFFFF, 0, 0));
      configure(64'hA5A5, 4, 65, 3, 0);
      send_beat(make_req(0, 64'd9, 32'd5, 0, 0));
      send_beat(make_req(0, 64'd9, 32'd194, 0, 0));
      send_beat(make_req(1, 64'd9, 0, 20'd0, 1));
      send_beat(make_req(1, 64'd9, 0, 20'd0, 0));
      drain();
      send_beat(make_req(1, 64'd9, 0, 20'd1040, 1));
   endtask

   task automatic run_phase(int items);
      int unsigned hb, nf, ns, grp;
      longint unsigned size;
      hbfb_pkg::req_type r;
      hb = (hash_bits > 16) ? 16 : hash_bits;
      nf = (filters == 0) ? 1 : (filters > 256 ? 256 : filters);
      ns = (seeds == 0) ? 1 : seeds;
      size = 64'd1 << hb;
      foreach (seed_pool[k]) seed_pool[k] = rand64();
      for (int n = 0; n < items; n++) begin
         grp = $urandom_range(3);
         if ($urandom_range(99) < 15) begin
            r = make_req($urandom_range(1), rand64(), $urandom, $urandom, $urandom_range(1));
         end else if ($urandom_range(1)) begin
            r = make_req(0, seed_pool[$urandom_range(7)],
                         grp * ns * nf + $urandom_range(ns * nf - 1), $urandom, $urandom_range(1));
         end else begin
            r = make_req(1, seed_pool[$urandom_range(7)], $urandom,
                         32'((grp * nf * size) & 20'hFFFFF), $urandom_range(1));
         end
         send_beat(r);
      end
   endtask

   task automatic test_random();
      int hb;
      for (int ph = 0; ph < 6; ph++) begin
         hb = $urandom_range(10);
         configure(rand64(), hb, (ph == 5) ? 256 : $urandom_range(1, 80),
                   $urandom_range(1, 4), $urandom_range(1));
         gaps_on = (ph != 2);
         run_phase(70);
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_pause_until_drained();
      configure(64'h0, 6, 128, 2, 0);
      run_phase(10);
      drain();
      run_phase(10);
   endtask

   initial begin
      xor_key = 0;
      hash_bits = 10;
      filters = 256;
      seeds = 1;
      layout = 1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_extremes();
      test_pause_until_drained();
      test_random();
      wait (pending_beats.size() == 0);
      repeat (600) @(posedge clock);
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
